/* hdl/straight_drive_pd_steering_top_assert.svh */
// assertion macros for the straight drive pd steering checker
`ifndef STRAIGHT_DRIVE_PD_STEERING_TOP_ASSERT_SVH
`define STRAIGHT_DRIVE_PD_STEERING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// types, constants and arithmetic helpers of the straight drive pd steering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int unsigned TICKS_PER_BLOCK = 160;
    localparam int unsigned STOP_OFFSET     = 10;
    localparam int unsigned BRAKE_SPEED     = 100;
    localparam int unsigned GAIN_FRAC_BITS  = 12;

    localparam int unsigned COUNT_W = 12;
    localparam int unsigned TERM_W  = 27;
    localparam int unsigned SPD_W   = 30;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_CENTER_OFFSET = 3'd0,
        CFG_KP_SIDE       = 3'd1,
        CFG_KD_SIDE       = 3'd2,
        CFG_KP_WHEEL      = 3'd3,
        CFG_KD_WHEEL      = 3'd4,
        CFG_BASE_SPEED    = 3'd5,
        CFG_SPEED_UPPER   = 3'd6,
        CFG_SPEED_LOWER   = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_BRAKE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DRV_STOP    = 2'd0,
        DRV_FORWARD = 2'd1,
        DRV_REVERSE = 2'd2
    } drive_t;

    typedef struct packed {
        logic signed [10:0] center_offset;
        logic [11:0]        kp_side;
        logic [11:0]        kd_side;
        logic [11:0]        kp_wheel;
        logic [11:0]        kd_wheel;
        logic [7:0]         base_speed;
        logic [7:0]         speed_upper;
        logic [7:0]         speed_lower;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [4:0] cells;
        logic [9:0] side_left;
        logic [9:0] side_right;
        logic [3:0] ticks_left;
        logic [3:0] ticks_right;
    } item_t;

    typedef struct packed {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        drive_t     left_drive;
        drive_t     right_drive;
        logic       buzzer;
        phase_t     run_phase;
        logic       finished;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] left_total;
        logic [COUNT_W-1:0] right_total;
        logic [COUNT_W-1:0] target_ticks;
        logic signed [11:0] last_side_error;
        logic signed [12:0] last_wheel_error;
        phase_t             phase;
        logic               buzzer;
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] total,
        input logic [3:0]         ticks
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, total} + {{(COUNT_W-3){1'b0}}, ticks};
        return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] calc_target(input logic [4:0] cells);
        logic [13:0] raw;
        logic [13:0] diff;
        raw  = {9'b0, cells} * 14'(TICKS_PER_BLOCK);
        diff = raw - 14'(STOP_OFFSET);
        if (raw < 14'(STOP_OFFSET))
        begin
            return '0;
        end
        else if (diff > 14'({COUNT_W{1'b1}}))
        begin
            return {COUNT_W{1'b1}};
        end
        return diff[COUNT_W-1:0];
    endfunction

    // gain * value / 2^frac, rounded toward zero
    function automatic logic signed [TERM_W-1:0] gain_term(
        input logic [11:0]        gain,
        input logic signed [13:0] value
    );
        logic signed [TERM_W-1:0] prod;
        logic signed [TERM_W-1:0] bias;
        prod = $signed({1'b0, gain}) * value;
        bias = prod[TERM_W-1] ? TERM_W'((1 << GAIN_FRAC_BITS) - 1) : '0;
        return (prod + bias) >>> GAIN_FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

/* hdl/sps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sps_cfg_regs
// configuration register file with reset values, written one index at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [sps_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [sps_pkg::CFG_W-1:0] cfg_data,
    output sps_pkg::cfg_t                  cfg
);

    sps_pkg::cfg_t cfg_reg;
    sps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (sps_pkg::cfg_index_t'(cfg_index))
                sps_pkg::CFG_CENTER_OFFSET: cfg_next.center_offset = $signed(cfg_data[10:0]);
                sps_pkg::CFG_KP_SIDE:       cfg_next.kp_side       = cfg_data;
                sps_pkg::CFG_KD_SIDE:       cfg_next.kd_side       = cfg_data;
                sps_pkg::CFG_KP_WHEEL:      cfg_next.kp_wheel      = cfg_data;
                sps_pkg::CFG_KD_WHEEL:      cfg_next.kd_wheel      = cfg_data;
                sps_pkg::CFG_BASE_SPEED:    cfg_next.base_speed    = cfg_data[7:0];
                sps_pkg::CFG_SPEED_UPPER:   cfg_next.speed_upper   = cfg_data[7:0];
                sps_pkg::CFG_SPEED_LOWER:   cfg_next.speed_lower   = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_offset <= '0;
            cfg_reg.kp_side       <= 12'd328;
            cfg_reg.kd_side       <= 12'd20;
            cfg_reg.kp_wheel      <= 12'd2048;
            cfg_reg.kd_wheel      <= 12'd41;
            cfg_reg.base_speed    <= 8'd125;
            cfg_reg.speed_upper   <= 8'd255;
            cfg_reg.speed_lower   <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/sps_step.sv */
// ----------------------------------------------------------------------------
// sps_step
// one control step: wheel counts, pd corrections, clamps and run phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_step (
    input  sps_pkg::cfg_t    cfg,
    input  sps_pkg::state_t  state,
    input  sps_pkg::item_t   item,
    output sps_pkg::state_t  state_next,
    output sps_pkg::result_t result
);

    localparam int unsigned TW = sps_pkg::TERM_W;
    localparam int unsigned SW = sps_pkg::SPD_W;

    logic [sps_pkg::COUNT_W-1:0] left_sum;
    logic [sps_pkg::COUNT_W-1:0] right_sum;
    logic signed [11:0]          side_diff;
    logic signed [11:0]          side_err;
    logic signed [12:0]          wheel_err;
    logic signed [13:0]          side_err_x;
    logic signed [13:0]          side_delta;
    logic signed [13:0]          wheel_err_x;
    logic signed [13:0]          wheel_delta;
    logic signed [TW-1:0]        side_p;
    logic signed [TW-1:0]        side_d;
    logic signed [TW-1:0]        wheel_p;
    logic signed [TW-1:0]        wheel_d;
    logic signed [SW-1:0]        corr;
    logic signed [SW-1:0]        base_s;
    logic signed [SW-1:0]        upper_s;
    logic signed [SW-1:0]        lower_s;
    logic signed [SW-1:0]        left_spd;
    logic signed [SW-1:0]        right_spd;
    logic                        left_hi;
    logic                        left_lo;
    logic                        right_hi;
    logic                        right_lo;
    logic [7:0]                  left_out;
    logic [7:0]                  right_out;
    logic                        buzz_left;
    logic                        buzz_right;
    logic                        drive_end;
    logic                        brake_end;

    assign left_sum  = sps_pkg::sat_add(state.left_total, item.ticks_left);
    assign right_sum = sps_pkg::sat_add(state.right_total, item.ticks_right);

    assign side_diff   = $signed({2'b00, item.side_right}) - $signed({2'b00, item.side_left});
    assign side_err    = $signed({cfg.center_offset[10], cfg.center_offset}) - side_diff;
    assign wheel_err   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign side_err_x  = 14'(side_err);
    assign side_delta  = side_err_x - 14'(state.last_side_error);
    assign wheel_err_x = 14'(wheel_err);
    assign wheel_delta = wheel_err_x - 14'(state.last_wheel_error);

    assign side_p  = sps_pkg::gain_term(cfg.kp_side, side_err_x);
    assign side_d  = sps_pkg::gain_term(cfg.kd_side, side_delta);
    assign wheel_p = sps_pkg::gain_term(cfg.kp_wheel, wheel_err_x);
    assign wheel_d = sps_pkg::gain_term(cfg.kd_wheel, wheel_delta);

    assign corr      = SW'(wheel_p) + SW'(wheel_d) + SW'(side_p) + SW'(side_d);
    assign base_s    = $signed({{(SW-8){1'b0}}, cfg.base_speed});
    assign upper_s   = $signed({{(SW-8){1'b0}}, cfg.speed_upper});
    assign lower_s   = $signed({{(SW-8){1'b0}}, cfg.speed_lower});
    assign left_spd  = base_s + corr;
    assign right_spd = base_s - corr;

    // upper limit wins; buzzer: low sets, in range clears, right wheel first
    assign left_hi    = left_spd > upper_s;
    assign left_lo    = left_spd < lower_s;
    assign right_hi   = right_spd > upper_s;
    assign right_lo   = right_spd < lower_s;
    assign left_out   = left_hi ? cfg.speed_upper : (left_lo ? cfg.speed_lower : left_spd[7:0]);
    assign right_out  = right_hi ? cfg.speed_upper : (right_lo ? cfg.speed_lower : right_spd[7:0]);
    assign buzz_left  = left_hi ? state.buzzer : left_lo;
    assign buzz_right = right_hi ? buzz_left : right_lo;

    assign drive_end = (left_sum > state.target_ticks) || (right_sum > state.target_ticks);
    assign brake_end = (left_sum > sps_pkg::COUNT_W'(sps_pkg::STOP_OFFSET))
                    || (right_sum > sps_pkg::COUNT_W'(sps_pkg::STOP_OFFSET));

    always_comb
    begin
        state_next         = state;
        result.left_duty   = '0;
        result.right_duty  = '0;
        result.left_drive  = sps_pkg::DRV_STOP;
        result.right_drive = sps_pkg::DRV_STOP;
        result.finished    = 1'b0;
        if (sps_pkg::op_t'(item.operation) == sps_pkg::OP_START)
        begin
            state_next.left_total       = '0;
            state_next.right_total      = '0;
            state_next.target_ticks     = sps_pkg::calc_target(item.cells);
            state_next.last_side_error  = '0;
            state_next.last_wheel_error = '0;
            state_next.phase            = sps_pkg::PH_DRIVE;
            result.left_duty            = cfg.base_speed;
            result.right_duty           = cfg.base_speed;
            result.left_drive           = sps_pkg::DRV_FORWARD;
            result.right_drive          = sps_pkg::DRV_FORWARD;
        end
        else
        begin
            case (state.phase)
                sps_pkg::PH_DRIVE:
                begin
                    if (drive_end)
                    begin
                        state_next.left_total  = '0;
                        state_next.right_total = '0;
                        state_next.phase       = sps_pkg::PH_BRAKE;
                        result.left_duty       = 8'(sps_pkg::BRAKE_SPEED);
                        result.right_duty      = 8'(sps_pkg::BRAKE_SPEED);
                        result.left_drive      = sps_pkg::DRV_REVERSE;
                        result.right_drive     = sps_pkg::DRV_REVERSE;
                    end
                    else
                    begin
                        state_next.left_total       = left_sum;
                        state_next.right_total      = right_sum;
                        state_next.last_side_error  = side_err;
                        state_next.last_wheel_error = wheel_err;
                        state_next.buzzer           = buzz_right;
                        result.left_duty            = left_out;
                        result.right_duty           = right_out;
                        result.left_drive           = sps_pkg::DRV_FORWARD;
                        result.right_drive          = sps_pkg::DRV_FORWARD;
                    end
                end
                sps_pkg::PH_BRAKE:
                begin
                    if (brake_end)
                    begin
                        state_next.left_total  = '0;
                        state_next.right_total = '0;
                        state_next.phase       = sps_pkg::PH_IDLE;
                        result.finished        = 1'b1;
                    end
                    else
                    begin
                        state_next.left_total  = left_sum;
                        state_next.right_total = right_sum;
                        result.left_duty       = 8'(sps_pkg::BRAKE_SPEED);
                        result.right_duty      = 8'(sps_pkg::BRAKE_SPEED);
                        result.left_drive      = sps_pkg::DRV_REVERSE;
                        result.right_drive     = sps_pkg::DRV_REVERSE;
                    end
                end
                default:
                begin
                    state_next.phase = sps_pkg::PH_IDLE;
                end
            endcase
        end
        result.buzzer    = state_next.buzzer;
        result.run_phase = state_next.phase;
    end

endmodule

`default_nettype wire

/* hdl/straight_drive_pd_steering_top.sv */
// ----------------------------------------------------------------------------
// straight_drive_pd_steering_top
// pd steering of a two-wheel drive over a straight run of cells
//
//   channel   handshake               payload
//   input     in_valid / in_ready     operation cells side_* ticks_*
//   result    out_valid / out_ready   *_duty *_drive buzzer run_phase finished
//   config    cfg_write               cfg_index cfg_data
//
// one request per cycle sustained while the result is taken; a request passes
// the input register, then the step logic into the result register
// run state updates as the step logic writes the result register
// a stalled result holds both registers; the input register frees as soon
// as the result is taken
// reset returns configuration to defaults and the run to idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module straight_drive_pd_steering_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [sps_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [sps_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic [4:0]                cells,
    input  wire logic [9:0]                side_left,
    input  wire logic [9:0]                side_right,
    input  wire logic [3:0]                ticks_left,
    input  wire logic [3:0]                ticks_right,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     left_duty,
    output logic [7:0]                     right_duty,
    output logic [1:0]                     left_drive,
    output logic [1:0]                     right_drive,
    output logic                           buzzer,
    output logic [1:0]                     run_phase,
    output logic                           finished
);

    sps_pkg::cfg_t    cfg;
    sps_pkg::item_t   item_reg;
    sps_pkg::state_t  state_reg;
    sps_pkg::state_t  state_next;
    sps_pkg::result_t res_reg;
    sps_pkg::result_t res_next;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             step_fire;
    logic             in_fire;

    sps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sps_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    assign step_fire = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || step_fire;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                item_valid_reg <= 1'b0;
            end
            if (step_fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.operation   <= operation;
            item_reg.cells       <= cells;
            item_reg.side_left   <= side_left;
            item_reg.side_right  <= side_right;
            item_reg.ticks_left  <= ticks_left;
            item_reg.ticks_right <= ticks_right;
        end
        if (step_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_duty   = res_reg.left_duty;
    assign right_duty  = res_reg.right_duty;
    assign left_drive  = res_reg.left_drive;
    assign right_drive = res_reg.right_drive;
    assign buzzer      = res_reg.buzzer;
    assign run_phase   = res_reg.run_phase;
    assign finished    = res_reg.finished;

endmodule

`default_nettype wire

/* hdl/sps_port_checker.sv */
// ----------------------------------------------------------------------------
// sps_port_checker
// port-level checks of the straight drive pd steering, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "straight_drive_pd_steering_top_assert.svh"

module sps_port_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [7:0]                left_duty,
    input wire logic [7:0]                right_duty,
    input wire logic [1:0]                left_drive,
    input wire logic [1:0]                right_drive,
    input wire logic [1:0]                run_phase,
    input wire logic                      finished
);

    // stalled result holds
    `SPS_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(left_duty) && $stable(right_duty) && $stable(run_phase) && $stable(finished), "result changed while stalled")

    // end of run stops both motors
    `SPS_ASSERT_SAME(a_finish_stops, out_valid && finished, run_phase == sps_pkg::PH_IDLE && left_drive == sps_pkg::DRV_STOP && right_drive == sps_pkg::DRV_STOP && left_duty == 8'd0 && right_duty == 8'd0, "finished without stopped motors")

    // braking drives both wheels backward at brake duty
    `SPS_ASSERT_SAME(a_brake_reverse, out_valid && run_phase == sps_pkg::PH_BRAKE, left_drive == sps_pkg::DRV_REVERSE && right_drive == sps_pkg::DRV_REVERSE && left_duty == 8'(sps_pkg::BRAKE_SPEED) && right_duty == 8'(sps_pkg::BRAKE_SPEED) && !finished, "bad braking result")

    // driving keeps both wheels forward
    `SPS_ASSERT_SAME(a_drive_forward, out_valid && run_phase == sps_pkg::PH_DRIVE, left_drive == sps_pkg::DRV_FORWARD && right_drive == sps_pkg::DRV_FORWARD && !finished, "bad driving result")

endmodule

bind straight_drive_pd_steering_top sps_port_checker u_sps_port_checker (.*);

`default_nettype wire
